FILE: rtl/mrrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_pkg: shared types and constants of the reply checker
// Config and result records, status codes, register indexes, CRC-16 step.
// ----------------------------------------------------------------------------
package mrrc_pkg;

   localparam int unsigned MIN_REPLY_LEN   = 5;
   localparam int unsigned HEADER_LEN      = 5;   // addr, func, count, crc lo/hi
   localparam int unsigned WRITE_REPLY_LEN = 8;
   localparam int unsigned CRC_LEN         = 2;
   localparam int unsigned CSR_INDEX_W     = 8;
   localparam int unsigned CSR_DATA_W      = 8;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  EXC_FLAG = 8'h80;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;
   localparam logic REPLY_READ  = 1'b0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EXPECTED_SLAVE    = 8'd0,
      CSR_EXPECTED_FUNCTION = 8'd1,
      CSR_EXPECTED_COUNT    = 8'd2,
      CSR_REPLY_KIND        = 8'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_CRC       = 3'd2,
      STATUS_ADDR      = 3'd3,
      STATUS_EXCEPTION = 3'd4,
      STATUS_FUNCTION  = 3'd5,
      STATUS_COUNT     = 3'd6,
      STATUS_BAD_ARG   = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] expected_slave;
      logic [7:0] expected_function;
      logic [6:0] expected_count;
      logic       reply_kind;
   } cfg_type;

   typedef struct packed {
      logic       result_kind;
      logic [6:0] reg_index;
      logic [15:0] reg_value;
      status_type frame_status;
      logic [7:0] exception_code;
      logic       frame_done;
   } result_type;

   // Frame as seen once the current byte is taken in
   typedef struct packed {
      logic [16:0] frame_len;
      logic [15:0] crc_calc;
      logic [15:0] crc_rx;
      logic [7:0]  address_byte;
      logic [7:0]  function_byte;
      logic [7:0]  third_byte;
   } frame_view_type;

   // Reflected CRC-16, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/mrrc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_req_if: received byte channel
// One word is one reply byte plus its end-of-frame flag.
// ----------------------------------------------------------------------------
interface mrrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_frame;

   modport source (output valid, output rx_byte, output end_of_frame, input ready);
   modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

FILE: rtl/mrrc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_rsp_if: result channel
// One word is either a register word or the final frame status.
// ----------------------------------------------------------------------------
interface mrrc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [6:0]  reg_index;
   logic [15:0] reg_value;
   logic [2:0]  frame_status;
   logic [7:0]  exception_code;
   logic        frame_done;

   modport source (output valid, output result_kind, output reg_index, output reg_value,
                   output frame_status, output exception_code, output frame_done,
                   input ready);
   modport sink   (input valid, input result_kind, input reg_index, input reg_value,
                   input frame_status, input exception_code, input frame_done,
                   output ready);
endinterface

FILE: rtl/mrrc_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_csr_if: configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface mrrc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] addr;
   logic [7:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

FILE: rtl/mrrc_status.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_status: end-of-frame verdict
// Ordered checks over the completed frame; first failing check wins.
// ----------------------------------------------------------------------------
module mrrc_status
   import mrrc_pkg::*;
(
   input  frame_view_type view,
   input  cfg_type        cfg,
   output status_type     status,
   output logic [7:0]     exception_code
);

   logic [16:0] read_len_min;
   logic [7:0]  byte_count_exp;

   assign byte_count_exp = {cfg.expected_count, 1'b0};
   assign read_len_min   = 17'(HEADER_LEN) + {9'd0, byte_count_exp};

   always_comb begin
      exception_code = 8'h00;
      if (view.frame_len < 17'(MIN_REPLY_LEN)) begin
         status = STATUS_SHORT;
      end else if (view.crc_rx != view.crc_calc) begin
         status = STATUS_CRC;
      end else if (view.address_byte != cfg.expected_slave) begin
         status = STATUS_ADDR;
      end else if ((view.function_byte & EXC_FLAG) != 8'h00) begin
         if (view.frame_len < 17'(HEADER_LEN)) begin
            status = STATUS_SHORT;
         end else begin
            status         = STATUS_EXCEPTION;
            exception_code = view.third_byte;
         end
      end else if (view.function_byte != cfg.expected_function) begin
         status = STATUS_FUNCTION;
      end else if (cfg.reply_kind == REPLY_READ) begin
         if (cfg.expected_count == 7'd0) begin
            status = STATUS_BAD_ARG;
         end else if (view.frame_len < read_len_min) begin
            status = STATUS_SHORT;
         end else if (view.third_byte != byte_count_exp) begin
            status = STATUS_COUNT;
         end else begin
            status = STATUS_OK;
         end
      end else if (view.frame_len < 17'(WRITE_REPLY_LEN)) begin
         status = STATUS_SHORT;
      end else begin
         status = STATUS_OK;
      end
   end

endmodule

FILE: rtl/mrrc_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrc_frame: per-frame tracking
// Byte count, CRC over bytes leaving the two-byte hold pipe, header bytes,
// register word assembly and the result for the current byte.
// ----------------------------------------------------------------------------
module mrrc_frame
   import mrrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic       end_of_frame,
   input  cfg_type    cfg,
   output logic       has_result,
   output result_type result
);

   logic [15:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  third_ff, third_in;
   logic [7:0]  high_ff, high_in;

   logic           word_byte;
   logic           word_ready;
   logic [14:0]    word_index;
   frame_view_type view;
   status_type     status;
   logic [7:0]     exc_code;

   assign crc_in   = (count_ff >= 16'(CRC_LEN)) ? crc_byte(crc_ff, held0_ff) : crc_ff;
   assign held0_in = held1_ff;
   assign held1_in = rx_byte;
   assign addr_in  = (count_ff == 16'd0) ? rx_byte : addr_ff;
   assign func_in  = (count_ff == 16'd1) ? rx_byte : func_ff;
   assign third_in = (count_ff == 16'd2) ? rx_byte : third_ff;
   assign count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;

   // data area starts at byte 3: odd positions carry the high byte
   assign high_in    = (count_ff >= 16'd3 && count_ff[0]) ? rx_byte : high_ff;
   assign word_byte  = (count_ff >= 16'd4) && !count_ff[0];
   assign word_index = 15'((count_ff - 16'd4) >> 1);
   assign word_ready = word_byte && (cfg.reply_kind == REPLY_READ)
                       && (word_index < {8'd0, cfg.expected_count});

   assign view.frame_len     = {1'b0, count_ff} + 17'd1;
   assign view.crc_calc      = crc_in;
   assign view.crc_rx        = {rx_byte, held1_ff};
   assign view.address_byte  = addr_in;
   assign view.function_byte = func_in;
   assign view.third_byte    = third_in;

   mrrc_status u_status (
      .view           (view),
      .cfg            (cfg),
      .status         (status),
      .exception_code (exc_code)
   );

   assign has_result = end_of_frame || word_ready;

   always_comb begin
      if (end_of_frame) begin
         result.result_kind    = KIND_STATUS;
         result.reg_index      = 7'd0;
         result.reg_value      = 16'd0;
         result.frame_status   = status;
         result.exception_code = exc_code;
         result.frame_done     = 1'b1;
      end else begin
         result.result_kind    = KIND_WORD;
         result.reg_index      = word_index[6:0];
         result.reg_value      = {high_ff, rx_byte};
         result.frame_status   = STATUS_OK;
         result.exception_code = 8'h00;
         result.frame_done     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_frame)) begin
         count_ff <= 16'd0;
         crc_ff   <= CRC_INIT;
         held0_ff <= 8'h00;
         held1_ff <= 8'h00;
         addr_ff  <= 8'h00;
         func_ff  <= 8'h00;
         third_ff <= 8'h00;
         high_ff  <= 8'h00;
      end else if (step) begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         third_ff <= third_in;
         high_ff  <= high_in;
      end
   end

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      step && end_of_frame |=> count_ff == 16'd0 && crc_ff == CRC_INIT)
      else $error("frame state not cleared after end of frame");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      step && !end_of_frame && count_ff != COUNT_MAX |=> count_ff == $past(count_ff) + 16'd1)
      else $error("byte count did not advance");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      step && !end_of_frame |=> held1_ff == $past(rx_byte) && held0_ff == $past(held1_ff))
      else $error("hold pipe out of step");

endmodule

FILE: rtl/modbus_rtu_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_reply_checker: Modbus RTU reply checker
// Takes reply bytes and returns register words and a final frame status.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch: one word per received byte, end_of_frame set on the last one.
//  - rsp_ch: zero or one word per byte. In read mode each register word
//    goes out as its low byte arrives (provisional, good only if the frame
//    status is ok); the last byte always yields the status word with
//    frame_done set and, for an exception reply, the exception code.
//  - csr_ch: register index + data, always ready; 0 slave, 1 function,
//    2 word count, 3 reply kind. Write only between frames.
// Timing: a byte lands in the input register; when it moves on, it runs
// through the CRC step and checks into the result register, which drives
// rsp valid. Throughput is one byte per cycle while rsp_ch.ready stays
// high. No clearing pass.
// Reset (synchronous): config back to slave 1, function 3, count 1, read
// mode; frame state cleared, both registers empty.
// Stall: a held result blocks only a byte that also produces a result;
// bytes without a result keep flowing, and req_ch.ready drops once the
// input register is full and cannot move.
// ----------------------------------------------------------------------------
module modbus_rtu_reply_checker
   import mrrc_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   mrrc_req_if.sink   req_ch,
   mrrc_rsp_if.source rsp_ch,
   mrrc_csr_if.sink   csr_ch
);

   // configuration registers
   cfg_type cfg_ff;

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;

   // result stage
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       frame_has_result;
   result_type frame_result;
   logic       out_free;
   logic       in_advance;
   logic       req_take;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_slave    <= 8'd1;
         cfg_ff.expected_function <= 8'd3;
         cfg_ff.expected_count    <= 7'd1;
         cfg_ff.reply_kind        <= REPLY_READ;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.addr))
            CSR_EXPECTED_SLAVE:    cfg_ff.expected_slave    <= csr_ch.wdata;
            CSR_EXPECTED_FUNCTION: cfg_ff.expected_function <= csr_ch.wdata;
            CSR_EXPECTED_COUNT:    cfg_ff.expected_count    <= csr_ch.wdata[6:0];
            CSR_REPLY_KIND:        cfg_ff.reply_kind        <= csr_ch.wdata[0];
            default: ;
         endcase
      end
   end

   // the byte in the input register moves on when its result has a place
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign in_advance   = in_valid_ff && (out_free || !frame_has_result);
   assign req_ch.ready = !in_valid_ff || in_advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_take) begin
         in_byte_ff <= req_ch.rx_byte;
         in_eof_ff  <= req_ch.end_of_frame;
      end
   end

   mrrc_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .step         (in_advance),
      .rx_byte      (in_byte_ff),
      .end_of_frame (in_eof_ff),
      .cfg          (cfg_ff),
      .has_result   (frame_has_result),
      .result       (frame_result)
   );

   always_comb begin
      if (in_advance && frame_has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (in_advance && frame_has_result) begin
         out_ff <= frame_result;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.result_kind    = out_ff.result_kind;
   assign rsp_ch.reg_index      = out_ff.reg_index;
   assign rsp_ch.reg_value      = out_ff.reg_value;
   assign rsp_ch.frame_status   = out_ff.frame_status;
   assign rsp_ch.exception_code = out_ff.exception_code;
   assign rsp_ch.frame_done     = out_ff.frame_done;

   a_status_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.frame_done |->
         out_ff.result_kind == KIND_STATUS && out_ff.reg_value == 16'd0
         && out_ff.reg_index == 7'd0)
      else $error("status word carries register data");

   a_data_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.frame_done |->
         out_ff.result_kind == KIND_WORD && out_ff.frame_status == STATUS_OK
         && out_ff.exception_code == 8'h00)
      else $error("register word carries status");

   a_exc_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.exception_code != 8'h00 |->
         out_ff.frame_status == STATUS_EXCEPTION)
      else $error("exception code without exception status");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eof_ff))
      else $error("input register lost a byte");

endmodule
